// File: src/average_pixel_predictor_assert.svh
// Assertion macros for the average pixel predictor.
// Included by the modules that check their own logic; needs clk_i and rst_ni in scope.
`ifndef AVERAGE_PIXEL_PREDICTOR_ASSERT_SVH
`define AVERAGE_PIXEL_PREDICTOR_ASSERT_SVH

// Checked only while out of reset.
`define APP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("average_pixel_predictor: assertion failed");

// Checked at every edge, reset included.
`define APP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("average_pixel_predictor: assertion failed during reset");

`endif

// File: src/app_pkg.sv
// Shared types and constants of the average pixel predictor.
// No dependencies; used by app_chan_res and the top level average_pixel_predictor.
package app_pkg;

  localparam int MaxWidth = 4096;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidthW   = 13;
  localparam int HeightW  = 16;
  localparam int PixW     = 32;
  localparam int ChanW    = 8;
  localparam int NumChan  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFourChannels = 2'd2;

  typedef enum logic [1:0] {
    PRED_NONE,
    PRED_LEFT,
    PRED_UP,
    PRED_AVG
  } pred_mode_e;

endpackage

// File: src/app_ram.sv
// Generic simple dual-port RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
module app_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/app_chan_res.sv
// Residual of one 8-bit channel against its left/up prediction.
// Depends on app_pkg for the prediction mode.
module app_chan_res (
  input  app_pkg::pred_mode_e           mode_i,
  input  logic [app_pkg::ChanW-1:0]     x_i,
  input  logic [app_pkg::ChanW-1:0]     left_i,
  input  logic [app_pkg::ChanW-1:0]     up_i,
  output logic [app_pkg::ChanW-1:0]     res_o
);

  logic [app_pkg::ChanW:0]   sum;
  logic [app_pkg::ChanW-1:0] pred;

  assign sum = {1'b0, left_i} + {1'b0, up_i};

  always_comb begin
    case (mode_i)
      app_pkg::PRED_NONE: pred = '0;
      app_pkg::PRED_LEFT: pred = left_i;
      app_pkg::PRED_UP:   pred = up_i;
      app_pkg::PRED_AVG:  pred = sum[app_pkg::ChanW:1];
      default:            pred = '0;
    endcase
  end

  // Residual wraps modulo 256.
  assign res_o = x_i - pred;

endmodule

// File: src/average_pixel_predictor.sv
// Top level of the average pixel predictor: position counters, line buffer, output register.
// Depends on app_pkg, app_ram, app_chan_res and average_pixel_predictor_assert.svh.
//
//   Channel   Direction  Handshake                 Content
//   s_axis    in         tvalid/tready             one pixel, chan0..chan3
//   m_axis    out        tvalid/tready             one residual, tlast = frame_last
//   cfg       in         cfg_we_i, write only      image_width, image_height, four_channels
//
// One item per clock sustained while m_axis is ready; an item taken from s_axis passes
// through the middle stage and then the output register before its residual is on m_axis.
// The line buffer is read at the current column as the item is taken and the new pixel
// is written to that entry in the same cycle; the read returns the row above.
// Reset clears counters, the left pixel and valid flags; the line buffer is not cleared.
// A stall on m_axis holds the output register, then the middle stage, then s_axis.
`include "average_pixel_predictor_assert.svh"

module average_pixel_predictor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // chan0_in [7:0], chan1_in [15:8], chan2_in [23:16], chan3_in [31:24]
  input  logic [app_pkg::PixW-1:0]        s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // chan0_res [7:0], chan1_res [15:8], chan2_res [23:16], chan3_res [31:24]
  output logic [app_pkg::PixW-1:0]        m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [app_pkg::CfgIdxW-1:0]     cfg_addr_i,
  input  logic [app_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  localparam int ColW  = app_pkg::ColW;
  localparam int ChanW = app_pkg::ChanW;

  // Configuration registers.
  logic [app_pkg::WidthW-1:0]  width_q;
  logic [app_pkg::HeightW-1:0] height_q;
  logic                        four_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= app_pkg::WidthW'(1);
      height_q <= app_pkg::HeightW'(1);
      four_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        app_pkg::RegImageWidth:   width_q  <= cfg_wdata_i[app_pkg::WidthW-1:0];
        app_pkg::RegImageHeight:  height_q <= cfg_wdata_i[app_pkg::HeightW-1:0];
        app_pkg::RegFourChannels: four_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Position of the incoming item.
  logic [ColW-1:0]             col_q, col_d, col_eff, wm1;
  logic [app_pkg::HeightW-1:0] row_q, row_d, hm1;
  logic                        last_col, last_row, accept;
  logic [app_pkg::PixW-1:0]    pix, left_q;
  app_pkg::pred_mode_e         mode;

  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (width_q > app_pkg::WidthW'(app_pkg::MaxWidth)) begin
      wm1 = ColW'(app_pkg::MaxWidth - 1);
    end else begin
      wm1 = ColW'(width_q - app_pkg::WidthW'(1));
    end
    hm1 = (height_q == '0) ? '0 : height_q - app_pkg::HeightW'(1);
  end

  assign last_col = (col_q >= wm1);
  assign last_row = (row_q >= hm1);
  assign col_eff  = last_col ? wm1 : col_q;

  assign pix = {four_q ? s_axis_tdata[4*ChanW-1:3*ChanW] : {ChanW{1'b0}},
                s_axis_tdata[3*ChanW-1:0]};

  always_comb begin
    if (row_q == '0) begin
      mode = (col_eff == '0) ? app_pkg::PRED_NONE : app_pkg::PRED_LEFT;
    end else begin
      mode = (col_eff == '0) ? app_pkg::PRED_UP : app_pkg::PRED_AVG;
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + app_pkg::HeightW'(1);
      end else begin
        col_d = col_eff + ColW'(1);
      end
    end
  end

  // Middle stage waits for the line buffer read.
  logic                      s1_valid_q, s1_last_q, s1_four_q, s1_adv;
  logic [app_pkg::PixW-1:0]  s1_pix_q, s1_left_q, up_pix;
  app_pkg::pred_mode_e       s1_mode_q;

  logic                      out_valid_q, out_last_q;
  logic [app_pkg::PixW-1:0]  out_data_q, res;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept) begin
        left_q <= pix;
      end
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pix;
      s1_left_q <= left_q;
      s1_mode_q <= mode;
      s1_last_q <= last_col && last_row;
      s1_four_q <= four_q;
    end
    if (s1_adv && s1_valid_q) begin
      out_data_q <= {s1_four_q ? res[4*ChanW-1:3*ChanW] : {ChanW{1'b0}},
                     res[3*ChanW-1:0]};
      out_last_q <= s1_last_q;
    end
  end

  // Read and write hit the same entry in one cycle; the RAM returns the old row.
  app_ram #(
    .Width (app_pkg::PixW),
    .Depth (app_pkg::MaxWidth)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_eff),
    .wdata_i (pix),
    .re_i    (accept),
    .raddr_i (col_eff),
    .rdata_o (up_pix)
  );

  for (genvar k = 0; k < app_pkg::NumChan; k++) begin : g_chan
    app_chan_res u_chan_res (
      .mode_i (s1_mode_q),
      .x_i    (s1_pix_q[k*ChanW +: ChanW]),
      .left_i (s1_left_q[k*ChanW +: ChanW]),
      .up_i   (up_pix[k*ChanW +: ChanW]),
      .res_o  (res[k*ChanW +: ChanW])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `APP_ASSERT(a_ready_when_out_free, !out_valid_q |-> s_axis_tready)
  `APP_ASSERT(a_accept_fills_stage, accept |=> s1_valid_q)
  `APP_ASSERT(a_row_end_wraps_col, (accept && last_col) |=> (col_q == '0))
  `APP_ASSERT(a_stall_keeps_stage, (s1_valid_q && !s1_adv) |=> s1_valid_q)
  `APP_ASSERT_ALWAYS(a_reset_no_output, !rst_ni |-> !m_axis_tvalid)

endmodule
